>>> rtl/nss_pkg.sv
// Shared types and constants for the next stage selector.
// Used by nss_core and next_stage_selector; depends on nothing else.
package nss_pkg;

	localparam int MAX_STAGES = 8;
	localparam int STAGE_W    = 4;
	localparam int MASK_W     = 8;
	localparam int ROW_W      = 64;
	localparam int CFG_IDX_W  = 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_STAGE_COUNT = 2'd0,
		REG_MAIN_STAGE  = 2'd1,
		REG_ROWS_LOW    = 2'd2,
		REG_ROWS_HIGH   = 2'd3
	} nss_reg_t;

	// Change codes; the two remaining codes mean second pass only.
	localparam logic [1:0] CODE_ALLOWED = 2'd0;
	localparam logic [1:0] CODE_BANNED  = 2'd1;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_CAND = 2'd1,
		ST_WALK = 2'd2
	} nss_state_t;

	typedef struct packed {
		logic [STAGE_W-1:0] current_stage;
		logic [MASK_W-1:0]  demand_mask;
	} nss_in_t;

	typedef struct packed {
		logic [STAGE_W-1:0] next_stage;
		logic               reversionary_inserted;
	} nss_out_t;

	// Register contents handed from the register file to the sequencer.
	typedef struct packed {
		logic [STAGE_W-1:0] stage_count;
		logic [STAGE_W-1:0] main_stage;
		logic [ROW_W-1:0]   rows_low;
		logic [ROW_W-1:0]   rows_high;
	} nss_cfg_t;

endpackage

>>> rtl/nss_core.sv
// Search sequencer of the next stage selector: walks candidate stages one step per cycle.
// Depends on nss_pkg.
module nss_core
	import nss_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  nss_cfg_t cfg,
	input  logic     start,
	input  nss_in_t  item,
	output logic     busy,
	output logic     done,
	output nss_out_t result
);

	nss_state_t         state_q, state_d;
	logic [STAGE_W-1:0] cur_q, cur_d;
	logic [STAGE_W-1:0] cnt_q, cnt_d;
	logic [STAGE_W-1:0] main_q, main_d;
	logic [MASK_W-1:0]  mask_q, mask_d;
	logic               pass_q, pass_d;
	logic               ins_q, ins_d;
	logic [STAGE_W-1:0] i_q, i_d;
	logic [STAGE_W-1:0] k_q, k_d;
	logic               done_q, done_d;
	nss_out_t           result_q, result_d;

	// Effective register values for a new beat.
	logic [STAGE_W-1:0] cnt_eff;
	logic [STAGE_W-1:0] main_eff;
	logic [MASK_W-1:0]  mask_eff;
	logic               cur_ok;

	always_comb begin
		if (cfg.stage_count < 4'd2) begin
			cnt_eff = 4'd2;
		end else if (cfg.stage_count > 4'(MAX_STAGES)) begin
			cnt_eff = 4'(MAX_STAGES);
		end else begin
			cnt_eff = cfg.stage_count;
		end
		main_eff = (cfg.main_stage > cnt_eff) ? '0 : cfg.main_stage;
		mask_eff = item.demand_mask & MASK_W'((9'd1 << cnt_eff) - 9'd1);
		cur_ok   = (item.current_stage != '0) && (item.current_stage <= cnt_eff);
	end

	// Candidate k = cur + i, wrapped into 1..count.
	logic [STAGE_W:0]   cand_sum;
	logic [STAGE_W-1:0] cand;
	logic [2:0]         cand_bit;

	always_comb begin
		cand_sum = {1'b0, cur_q} + {1'b0, i_q};
		if (cand_sum > {1'b0, cnt_q}) begin
			cand = STAGE_W'(cand_sum - {1'b0, cnt_q});
		end else begin
			cand = STAGE_W'(cand_sum);
		end
		cand_bit = 3'(cand - 4'd1);
	end

	// Change code lookup from the running stage to stage k.
	logic [ROW_W-1:0] row;
	logic [5:0]       code_pos;
	logic [1:0]       code;

	always_comb begin
		row      = (cur_q <= 4'd4) ? cfg.rows_low : cfg.rows_high;
		code_pos = {2'(cur_q - 4'd1), 3'(k_q - 4'd1), 1'b0};
		code     = row[code_pos +: 2];
	end

	// Reversionary insertion check at the end of a failed search.
	logic [2:0] main_bit;
	logic       can_insert;

	always_comb begin
		main_bit   = 3'(main_q - 4'd1);
		can_insert = !ins_q && (main_q != '0) && (main_q != cur_q) && !mask_q[main_bit];
	end

	// State register and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q    <= cur_d;
		cnt_q    <= cnt_d;
		main_q   <= main_d;
		mask_q   <= mask_d;
		pass_q   <= pass_d;
		ins_q    <= ins_d;
		i_q      <= i_d;
		k_q      <= k_d;
		result_q <= result_d;
	end

	// Next state and sequencing.
	always_comb begin
		state_d  = state_q;
		cur_d    = cur_q;
		cnt_d    = cnt_q;
		main_d   = main_q;
		mask_d   = mask_q;
		pass_d   = pass_q;
		ins_d    = ins_q;
		i_d      = i_q;
		k_d      = k_q;
		done_d   = 1'b0;
		result_d = result_q;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cur_d  = item.current_stage;
					cnt_d  = cnt_eff;
					main_d = main_eff;
					mask_d = mask_eff;
					pass_d = 1'b0;
					ins_d  = 1'b0;
					i_d    = 4'd1;
					if (cur_ok) begin
						state_d = ST_CAND;
					end else begin
						done_d   = 1'b1;
						result_d = '0;
					end
				end
			end
			ST_CAND: begin
				if (i_q == cnt_q) begin
					// End of a pass.
					if (!pass_q) begin
						pass_d = 1'b1;
						i_d    = 4'd1;
					end else if (can_insert) begin
						mask_d           = mask_q | (MASK_W'(1) << main_bit);
						ins_d            = 1'b1;
						pass_d           = 1'b0;
						i_d              = 4'd1;
					end else begin
						state_d  = ST_IDLE;
						done_d   = 1'b1;
						result_d = '{next_stage: '0, reversionary_inserted: ins_q};
					end
				end else begin
					i_d = i_q + 4'd1;
					if (mask_q[cand_bit]) begin
						k_d     = cand;
						state_d = ST_WALK;
					end
				end
			end
			ST_WALK: begin
				if (k_q == cur_q) begin
					state_d = ST_CAND;
				end else if (code == CODE_ALLOWED || (code != CODE_BANNED && pass_q)) begin
					state_d  = ST_IDLE;
					done_d   = 1'b1;
					result_d = '{next_stage: k_q, reversionary_inserted: ins_q};
				end else if (code == CODE_BANNED) begin
					// Walk back one stage, wrapping below stage 1.
					k_d = (k_q == 4'd1) ? cnt_q : (k_q - 4'd1);
				end else begin
					state_d = ST_CAND;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// A result never comes out while a search is still running.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == ST_IDLE)
		else $error("result strobe while sequencer busy");

	// A chosen stage is within the count and differs from the running stage.
	a_next_range: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (result_q.next_stage == '0) ||
			(result_q.next_stage <= cnt_q && result_q.next_stage != cur_q))
		else $error("chosen stage out of range");

	// The walk index stays within the stages in use.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> (k_q != '0) && (k_q <= cnt_q))
		else $error("walk index out of range");

	// A reversionary demand is only inserted at the end of a failed search.
	a_ins_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ins_q) |-> $past(state_q) == ST_CAND)
		else $error("reversionary insert outside candidate step");

endmodule

>>> rtl/next_stage_selector.sv
// An out-of-range current stage gives the result strobe in the cycle after start.
// Otherwise the sequencer takes one step per candidate and one per walk step, with one
// code lookup per walk step, over at most two searches of two passes each.
// One beat at a time: busy stays high until the result strobe; done cannot be stalled.
// Reset (arst_n low) returns the sequencer to idle and the registers to count 4,
// main stage none and all change codes allowed.
// Top level of the next stage selector: configuration registers and the search sequencer.
// Depends on nss_pkg and nss_core.
module next_stage_selector
	import nss_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]     cfg_data,
	input  logic                 start,
	input  nss_in_t              item,
	output logic                 busy,
	output logic                 done,
	output nss_out_t             result
);

	nss_cfg_t cfg_q;

	// Configuration register file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stage_count <= 4'd4;
			cfg_q.main_stage  <= '0;
			cfg_q.rows_low    <= '0;
			cfg_q.rows_high   <= '0;
		end else if (cfg_we) begin
			unique case (nss_reg_t'(cfg_index))
				REG_STAGE_COUNT: cfg_q.stage_count <= cfg_data[STAGE_W-1:0];
				REG_MAIN_STAGE:  cfg_q.main_stage  <= cfg_data[STAGE_W-1:0];
				REG_ROWS_LOW:    cfg_q.rows_low    <= cfg_data;
				REG_ROWS_HIGH:   cfg_q.rows_high   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	nss_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

endmodule
